// ----- rtl/core/dsd_pkg.sv -----
// Shared types, constants and character ROM for the digram string decoder.
package dsd_pkg;

	localparam int RomSize = 144;
	localparam logic [7:0] EscCode = 8'h1B;
	localparam logic [7:0] EscBase = 8'h7F;
	localparam logic [7:0] SecondOffset = 8'd16;
	localparam logic [7:0] EndCode = 8'h00;

	// Character i of the ROM sits at bits [8*(RomSize-1-i) +: 8].
	localparam logic [8*RomSize-1:0] DigramRom = {
		" etainosrlhcdupm",
		"tasio wb rnsdalm",
		"h ieorasnrtlc sy",
		"nstcloer dtgesio",
		"nr ufmsw tep.ica",
		"e oiadur laeiyod",
		"eia otruetoakhlr",
		" eiu,.oansrctlai",
		"leoiratpeaoip bm"
	};

	typedef struct packed {
		logic [7:0] chr;
		logic       last;
	} result_t;

	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
		logic       esc_next;
	} decode_t;

	typedef struct packed {
		logic       emit;
		logic [7:0] chr;
		logic       esc_next;
	} xlat_t;

	function automatic logic [7:0] rom_char(input logic [7:0] idx);
		logic [7:0] r;
		r = DigramRom[8*(RomSize-1-int'(idx)) +: 8];
		return r;
	endfunction

	// Escape translation of one character against the current pending flag.
	function automatic xlat_t translate(input logic [7:0] ch, input logic esc);
		xlat_t x;
		x.chr = ch;
		x.emit = 1'b1;
		x.esc_next = 1'b0;
		if (esc) begin
			x.chr = EscBase + ch;
		end else if (ch == EscCode) begin
			x.emit = 1'b0;
			x.esc_next = 1'b1;
		end
		return x;
	endfunction

endpackage

// ----- rtl/core/dsd_decode.sv -----
// Combinational expansion and escape translation of one compressed byte.
module dsd_decode (
	input  logic [7:0]      code_byte,
	input  logic            esc,
	output dsd_pkg::decode_t dec
);
	import dsd_pkg::*;

	logic [7:0] idx_a;
	logic [7:0] idx_b;
	xlat_t      xa;
	xlat_t      xb;
	xlat_t      xl;

	assign idx_a = {4'b0000, code_byte[6:3]};
	assign idx_b = {1'b0, code_byte[6:0]} + SecondOffset;

	always_comb begin
		xa = translate(rom_char(idx_a), esc);
		xb = translate(rom_char(idx_b), xa.esc_next);
		xl = translate(code_byte, esc);
		dec.count = 2'd0;
		dec.first = '{chr: 8'h00, last: 1'b0};
		dec.second = '{chr: 8'h00, last: 1'b0};
		dec.esc_next = esc;
		if (code_byte == EndCode) begin
			// A dangling escape at the end yields its base with a zero operand.
			dec.esc_next = 1'b0;
			if (esc) begin
				dec.count = 2'd2;
				dec.first = '{chr: EscBase, last: 1'b0};
				dec.second = '{chr: 8'h00, last: 1'b1};
			end else begin
				dec.count = 2'd1;
				dec.first = '{chr: 8'h00, last: 1'b1};
			end
		end else if (code_byte[7]) begin
			dec.esc_next = xb.esc_next;
			if (xa.emit) begin
				dec.first = '{chr: xa.chr, last: 1'b0};
				dec.second = '{chr: xb.chr, last: 1'b0};
				dec.count = xb.emit ? 2'd2 : 2'd1;
			end else begin
				dec.first = '{chr: xb.chr, last: 1'b0};
				dec.count = xb.emit ? 2'd1 : 2'd0;
			end
		end else begin
			dec.esc_next = xl.esc_next;
			dec.first = '{chr: xl.chr, last: 1'b0};
			dec.count = xl.emit ? 2'd1 : 2'd0;
		end
	end

endmodule

// ----- rtl/core/dsd_out_queue.sv -----
// Two-entry result queue that feeds the registered output channel.
module dsd_out_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_req,
	input  dsd_pkg::decode_t dec,
	output logic             push_ok,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       out_char,
	output logic             is_last
);
	import dsd_pkg::*;

	result_t    q0_q;
	result_t    q1_q;
	result_t    nxt0;
	result_t    nxt1;
	logic [1:0] count_q;
	logic [1:0] rem;
	logic [1:0] count_nxt;
	logic       pop;
	logic       push;

	assign out_valid = (count_q != 2'd0);
	assign out_char = q0_q.chr;
	assign is_last = q0_q.last;
	assign pop = out_valid && !out_stall;
	assign rem = count_q - {1'b0, pop};
	assign push_ok = (({1'b0, rem} + {1'b0, dec.count}) <= 3'd2);
	assign push = push_req && push_ok;
	assign count_nxt = push ? (rem + dec.count) : rem;

	always_comb begin
		unique case (rem)
			2'd0: begin
				nxt0 = dec.first;
				nxt1 = dec.second;
			end
			2'd1: begin
				nxt0 = pop ? q1_q : q0_q;
				nxt1 = dec.first;
			end
			default: begin
				nxt0 = q0_q;
				nxt1 = q1_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= count_nxt;
		end
	end

	// Entries past the count are don't-care, so they load every cycle.
	always_ff @(posedge clk) begin
		q0_q <= nxt0;
		q1_q <= nxt1;
	end

endmodule

// ----- rtl/core/digram_string_decoder_unit.sv -----
// Top level of the digram string decoder: input register, decode and result queue.
// The input register feeds the combinational decode, whose characters are queued.
// Throughput: one character per cycle on the output while out_stall is low;
// the single-character output channel sets this limit.
// Reset clears the input valid, the queue count and the pending escape flag.
module digram_string_decoder_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] code_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_char,
	output logic       is_last
);
	import dsd_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       esc_q;
	logic       push_ok;
	logic       take;
	decode_t    dec;

	dsd_decode u_decode (
		.code_byte(byte_s1),
		.esc      (esc_q),
		.dec      (dec)
	);

	dsd_out_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_req (valid_s1),
		.dec      (dec),
		.push_ok  (push_ok),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_char (out_char),
		.is_last  (is_last)
	);

	// The held byte leaves when the queue has room for all of its characters.
	assign take = valid_s1 && push_ok;
	assign in_stall = valid_s1 && !take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			esc_q <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (take) begin
				esc_q <= dec.esc_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= code_byte;
		end
	end

endmodule
